FILE: design/pssl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssl_pkg
// Shared widths, action and status codes and the controller state type of
// the priority sorted slot list.
// ----------------------------------------------------------------------------
package pssl_pkg;

   // field widths of the request and response
   localparam int ACTION_W   = 3;
   localparam int SLOT_ID_W  = 6;
   localparam int PRIO_W     = 16;
   localparam int HANDLE_W   = 16;
   localparam int STATUS_W   = 2;

   // default pool size, slot 0 is the list head
   localparam int SLOT_COUNT_DEF = 64;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_GET    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CHANGE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_WALK   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

   // response status
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_REJ   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ADD_SCAN,
      ST_ADD_LINK,
      ST_ADD_JOIN,
      ST_ACCESS,
      ST_WALK,
      ST_RESULT
   } state_type;

endpackage

FILE: design/pssl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssl_ram
// Generic single write port, single read port memory with registered read
// data. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module pssl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pssl_free_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssl_free_find
// Lowest free slot finder. A registered two level tree: first free slot in
// each group of eight, then the first group that has one. A change of the used
// bits reaches the answer through the group registers, then the output registers.
// ----------------------------------------------------------------------------
module pssl_free_find #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [SLOT_COUNT-1:0]         used,
   output logic                          free_any,
   output logic [$clog2(SLOT_COUNT)-1:0] free_slot
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int GRP    = 8;
   localparam int GROUPS = (SLOT_COUNT + GRP - 1) / GRP;

   logic [GROUPS*GRP-1:0] used_pad;
   logic [GROUPS-1:0]     grp_any_ff, grp_any_in;
   logic [2:0]            grp_idx_ff [GROUPS];
   logic [2:0]            grp_idx_in [GROUPS];
   logic                  free_any_ff, free_any_in;
   logic [IDX_W-1:0]      free_slot_ff, free_slot_in;

   // slots past the pool and the head count as used
   always_comb begin
      used_pad = '1;
      used_pad[SLOT_COUNT-1:0] = used;
      used_pad[0] = 1'b1;
   end

   // first level: lowest free slot inside each group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g] = 1'b0;
         grp_idx_in[g] = 3'd0;
         for (int k = GRP - 1; k >= 0; k--) begin
            if (!used_pad[g*GRP + k]) begin
               grp_any_in[g] = 1'b1;
               grp_idx_in[g] = 3'(k);
            end
         end
      end
   end

   // second level: lowest group holding a free slot
   always_comb begin
      free_any_in  = 1'b0;
      free_slot_in = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            free_any_in  = 1'b1;
            free_slot_in = IDX_W'(g*GRP + int'(grp_idx_ff[g]));
         end
      end
   end

   // tree registers, reset to the answer for an empty pool
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < GROUPS; g++) begin
            grp_any_ff[g] <= 1'b1;
            grp_idx_ff[g] <= (g == 0) ? 3'd1 : 3'd0;
         end
         free_any_ff  <= 1'b1;
         free_slot_ff <= IDX_W'(1);
      end else begin
         for (int g = 0; g < GROUPS; g++) begin
            grp_any_ff[g] <= grp_any_in[g];
            grp_idx_ff[g] <= grp_idx_in[g];
         end
         free_any_ff  <= free_any_in;
         free_slot_ff <= free_slot_in;
      end
   end

   assign free_any  = free_any_ff;
   assign free_slot = free_slot_ff;

endmodule

FILE: design/priority_sorted_slot_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sorted_slot_list
// Pool of task slots kept as a doubly linked list in ascending priority
// order, with slot 0 as list head. Links, priorities and handles live in
// four synchronous memories; used bits and the head link are flip-flops.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             fields
//  req       in         req_valid/req_stall   action, slot_id, priority_req, handle
//  rsp       out        rsp_valid/rsp_stall   status, slot_id_res, handle_res,
//                                             priority_res, last
//
//  one request at a time; get, change and delete pass dispatch, access and result
//  rejects skip to result; add scans the list in a memory read loop, then links
//  and joins the slot; walk emits one listed slot per step, one memory read per step
//  reset clears used bits and head link at once, no clearing pass
//  a stalled response holds; the list is only read ahead once it is taken
// ----------------------------------------------------------------------------
module priority_sorted_slot_list
   import pssl_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [SLOT_ID_W-1:0] req_slot_id,
   input  logic [PRIO_W-1:0]    req_priority_req,
   input  logic [HANDLE_W-1:0]  req_handle,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_ID_W-1:0] rsp_slot_id_res,
   output logic [HANDLE_W-1:0]  rsp_handle_res,
   output logic [PRIO_W-1:0]    rsp_priority_res,
   output logic                 rsp_last
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam logic [SLOT_COUNT-1:0] USED_RESET = SLOT_COUNT'(1);
   localparam logic [SLOT_ID_W:0]    SLOT_LIMIT = (SLOT_ID_W+1)'(SLOT_COUNT);

   state_type state_ff, state_in;

   // request copy
   logic [ACTION_W-1:0]  act_ff;
   logic [SLOT_ID_W-1:0] sid_ff;
   logic [PRIO_W-1:0]    prio_ff;
   logic [HANDLE_W-1:0]  hnd_ff;

   // list walking state
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [IDX_W-1:0]      p_ff, p_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [IDX_W-1:0]      head_next_ff, head_next_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;

   // pending single response
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [IDX_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [HANDLE_W-1:0] pend_hnd_ff, pend_hnd_in;
   logic [PRIO_W-1:0]   pend_prio_ff, pend_prio_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [SLOT_ID_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [HANDLE_W-1:0]  rsp_hnd_ff, rsp_hnd_in;
   logic [PRIO_W-1:0]    rsp_prio_ff, rsp_prio_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 out_free;
   logic                 out_load;

   // memory ports
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    next_rd, prev_rd;
   logic [PRIO_W-1:0]   prio_rd;
   logic [HANDLE_W-1:0] hnd_rd;
   logic                next_we, prev_we, prio_we, hnd_we;
   logic [IDX_W-1:0]    next_waddr, prev_waddr;
   logic [IDX_W-1:0]    next_wdata, prev_wdata;

   // free slot search
   logic             free_any;
   logic [IDX_W-1:0] free_slot;

   logic             req_accept;
   logic [IDX_W-1:0] sid_idx;
   logic             id_ok;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // slot id check for delete, get and change
   assign sid_idx = sid_ff[IDX_W-1:0];
   assign id_ok   = (sid_ff != '0) && ({1'b0, sid_ff} < SLOT_LIMIT) && used_ff[sid_idx];

   pssl_free_find #(.SLOT_COUNT(SLOT_COUNT)) u_free_find (
      .clock     (clock),
      .reset     (reset),
      .used      (used_ff),
      .free_any  (free_any),
      .free_slot (free_slot)
   );

   pssl_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_next_ram (
      .clock (clock), .wr_en (next_we), .wr_addr (next_waddr), .wr_data (next_wdata),
      .rd_en (rd_en), .rd_addr (rd_addr), .rd_data (next_rd)
   );

   pssl_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_prev_ram (
      .clock (clock), .wr_en (prev_we), .wr_addr (prev_waddr), .wr_data (prev_wdata),
      .rd_en (rd_en), .rd_addr (rd_addr), .rd_data (prev_rd)
   );

   pssl_ram #(.WIDTH(PRIO_W), .DEPTH(SLOT_COUNT)) u_prio_ram (
      .clock (clock), .wr_en (prio_we), .wr_addr (slot_ff), .wr_data (prio_ff),
      .rd_en (rd_en), .rd_addr (rd_addr), .rd_data (prio_rd)
   );

   pssl_ram #(.WIDTH(HANDLE_W), .DEPTH(SLOT_COUNT)) u_handle_ram (
      .clock (clock), .wr_en (hnd_we), .wr_addr (slot_ff), .wr_data (hnd_ff),
      .rd_en (rd_en), .rd_addr (rd_addr), .rd_data (hnd_rd)
   );

   // next state, memory accesses and response loading
   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      p_in           = p_ff;
      cur_in         = cur_ff;
      head_next_in   = head_next_ff;
      used_in        = used_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_hnd_in    = pend_hnd_ff;
      pend_prio_in   = pend_prio_ff;
      rd_en          = 1'b0;
      rd_addr        = cur_ff;
      next_we        = 1'b0;
      next_waddr     = slot_ff;
      next_wdata     = cur_ff;
      prev_we        = 1'b0;
      prev_waddr     = slot_ff;
      prev_wdata     = p_ff;
      prio_we        = 1'b0;
      hnd_we         = 1'b0;
      out_load       = 1'b0;
      rsp_status_in  = pend_status_ff;
      rsp_slot_in    = SLOT_ID_W'(pend_slot_ff);
      rsp_hnd_in     = pend_hnd_ff;
      rsp_prio_in    = pend_prio_ff;
      rsp_last_in    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            // default: rejected request
            pend_status_in = STAT_REJ;
            pend_slot_in   = '0;
            pend_hnd_in    = '0;
            pend_prio_in   = '0;
            state_in       = ST_RESULT;
            case (act_ff)
               ACT_ADD: begin
                  if (prio_ff != '0 && free_any) begin
                     slot_in = free_slot;
                     p_in    = '0;
                     cur_in  = head_next_ff;
                     if (head_next_ff == '0) begin
                        state_in = ST_ADD_LINK;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_next_ff;
                        state_in = ST_ADD_SCAN;
                     end
                  end
               end
               ACT_DELETE, ACT_GET, ACT_CHANGE: begin
                  if (id_ok) begin
                     slot_in  = sid_idx;
                     rd_en    = 1'b1;
                     rd_addr  = sid_idx;
                     state_in = ST_ACCESS;
                  end
               end
               ACT_WALK: begin
                  if (head_next_ff == '0) begin
                     pend_status_in = STAT_EMPTY;
                  end else begin
                     cur_in   = head_next_ff;
                     rd_en    = 1'b1;
                     rd_addr  = head_next_ff;
                     state_in = ST_WALK;
                  end
               end
               ACT_CLEAR: begin
                  used_in        = USED_RESET;
                  head_next_in   = '0;
                  pend_status_in = STAT_OK;
               end
               default: begin
               end
            endcase
         end

         ST_ADD_SCAN: begin
            // stop before the first entry with a higher priority
            if (prio_rd > prio_ff) begin
               state_in = ST_ADD_LINK;
            end else begin
               p_in   = cur_ff;
               cur_in = next_rd;
               if (next_rd == '0) begin
                  state_in = ST_ADD_LINK;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = next_rd;
               end
            end
         end

         ST_ADD_LINK: begin
            // fill the new slot, links to its neighbors
            next_we          = 1'b1;
            prev_we          = 1'b1;
            prio_we          = 1'b1;
            hnd_we           = 1'b1;
            used_in[slot_ff] = 1'b1;
            state_in         = ST_ADD_JOIN;
         end

         ST_ADD_JOIN: begin
            // neighbors point at the new slot
            prev_waddr = cur_ff;
            prev_wdata = slot_ff;
            prev_we    = (cur_ff != '0);
            next_waddr = p_ff;
            next_wdata = slot_ff;
            next_we    = (p_ff != '0);
            if (p_ff == '0) begin
               head_next_in = slot_ff;
            end
            pend_status_in = STAT_OK;
            pend_slot_in   = slot_ff;
            pend_hnd_in    = hnd_ff;
            pend_prio_in   = prio_ff;
            state_in       = ST_RESULT;
         end

         ST_ACCESS: begin
            pend_status_in = STAT_OK;
            pend_slot_in   = slot_ff;
            pend_hnd_in    = hnd_rd;
            pend_prio_in   = prio_rd;
            state_in       = ST_RESULT;
            case (act_ff)
               ACT_DELETE: begin
                  // unlink: neighbors point past the slot
                  prev_waddr       = next_rd;
                  prev_wdata       = prev_rd;
                  prev_we          = (next_rd != '0);
                  next_waddr       = prev_rd;
                  next_wdata       = next_rd;
                  next_we          = (prev_rd != '0);
                  if (prev_rd == '0) begin
                     head_next_in = next_rd;
                  end
                  used_in[slot_ff] = 1'b0;
               end
               ACT_CHANGE: begin
                  hnd_we      = 1'b1;
                  pend_hnd_in = hnd_ff;
               end
               default: begin
               end
            endcase
         end

         ST_WALK: begin
            // emit current slot, read ahead the next one
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_slot_in   = SLOT_ID_W'(cur_ff);
               rsp_hnd_in    = hnd_rd;
               rsp_prio_in   = prio_rd;
               rsp_last_in   = (next_rd == '0);
               if (next_rd == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_in  = next_rd;
                  rd_en   = 1'b1;
                  rd_addr = next_rd;
               end
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_next_ff <= '0;
         used_ff      <= USED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_next_ff <= head_next_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request copy
   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff  <= req_action;
         sid_ff  <= req_slot_id;
         prio_ff <= req_priority_req;
         hnd_ff  <= req_handle;
      end
   end

   // working and pending result registers
   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      p_ff           <= p_in;
      cur_ff         <= cur_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      pend_hnd_ff    <= pend_hnd_in;
      pend_prio_ff   <= pend_prio_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_hnd_ff    <= rsp_hnd_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_id_res  = rsp_slot_ff;
   assign rsp_handle_res   = rsp_hnd_ff;
   assign rsp_priority_res = rsp_prio_ff;
   assign rsp_last         = rsp_last_ff;

   // the slot taken by add must still be free
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD_LINK |-> !used_ff[slot_ff])
      else $error("add links a slot that is already used");

   // the insert scan only visits listed slots
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD_SCAN |-> used_ff[cur_ff])
      else $error("insert scan reached a free slot");

   // the walk only emits listed slots
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> used_ff[cur_ff])
      else $error("walk reached a free slot");

   // clear leaves an empty list
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISPATCH && act_ff == ACT_CLEAR)
      |=> (head_next_ff == '0 && used_ff == USED_RESET))
      else $error("clear did not empty the list");

endmodule
